>>> src/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int VAL_W   = 32;
    localparam int IDX_W   = 6;
    localparam int DEPTH   = 64;
    localparam int CNT_W   = 7;
    localparam int DIFF_W  = VAL_W + 1;
    localparam int MLO_W   = 17;
    localparam int MHI_W   = DIFF_W - MLO_W;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = PROD_W + 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BELOW = 2'd1;
    localparam logic [1:0] ST_ZERO  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef struct packed {
        logic                    operation;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] x_value;
        logic signed [VAL_W-1:0] y_value;
        logic                    end_of_batch;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] result_y;
        logic [1:0]              status;
        logic [IDX_W-1:0]        segment_index;
        logic                    batch_end;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [DIFF_W-1:0] divisor;
    } t_div_req;

endpackage

>>> src/pli_table.sv
// ----------------------------------------------------------------------------
// pli_table
// Breakpoint x and y memories, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pli_table (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [pli_pkg::IDX_W-1:0]        i_waddr,
    input  logic signed [pli_pkg::VAL_W-1:0] i_wx,
    input  logic signed [pli_pkg::VAL_W-1:0] i_wy,
    input  logic [pli_pkg::IDX_W-1:0]        i_raddr,
    output logic signed [pli_pkg::VAL_W-1:0] o_rx,
    output logic signed [pli_pkg::VAL_W-1:0] o_ry
);
    import pli_pkg::*;

    logic signed [VAL_W-1:0] mem_x [DEPTH];
    logic signed [VAL_W-1:0] mem_y [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem_x[i_waddr] <= i_wx;
            mem_y[i_waddr] <= i_wy;
        end
        o_rx <= mem_x[i_raddr];
        o_ry <= mem_y[i_raddr];
    end

endmodule

>>> src/pli_divider.sv
// ----------------------------------------------------------------------------
// pli_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pli_pkg::t_div_req           i_req,
    output logic                        o_done,
    output logic [pli_pkg::PROD_W-1:0]  o_quotient
);
    import pli_pkg::*;

    localparam int STEP_W = $clog2(PROD_W + 1);

    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [DIFF_W-1:0] r_rem;
    logic [PROD_W-1:0] r_quo;
    logic [DIFF_W-1:0] r_dvs;
    logic              r_done;

    logic [DIFF_W:0]   rem_sh;
    logic              ge;
    logic [DIFF_W:0]   rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_quo[PROD_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(PROD_W);
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[DIFF_W-1:0] : rem_sh[DIFF_W-1:0];
                r_quo <= {r_quo[PROD_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> src/piecewise_linear_interpolator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with a scanning search and iterative interpolation.
// ----------------------------------------------------------------------------
// Input beats carry a load (write one breakpoint) or a query. Each beat
// gives exactly one output beat, in order. Both channels are valid/ready.
// The user writes point_count via i_cfg_we/i_cfg_data only while idle;
// the block does not enforce this. A load passes through the finish state
// to its output register. A query scans the table one entry a cycle
// through the single read port, fetches the segment, forms differences,
// runs a two-step 33x17/33x16 multiply and the radix-2 divider with its
// start and done, and saturates; with no breakpoint at or below it, or a
// zero-width segment, it skips the arithmetic. point_count clamps to 2..64.
// One item is worked on at a time; the next input beat is taken
// once the result has moved into the output register.
// Reset clears the control state and sets point_count to 2; the tables
// are not cleared and must be loaded before they are searched.
// While the receiver stalls, the output beat holds; a finished result
// waits in the block until the output register frees.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  pli_pkg::t_in_item           i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output pli_pkg::t_out_item          o_out_data,
    input  logic                        i_cfg_we,
    input  logic [pli_pkg::CNT_W-1:0]   i_cfg_data
);
    import pli_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_F0   = 4'd2;
    localparam logic [3:0] S_F1   = 4'd3;
    localparam logic [3:0] S_F2   = 4'd4;
    localparam logic [3:0] S_CALC = 4'd5;
    localparam logic [3:0] S_MUL0 = 4'd6;
    localparam logic [3:0] S_MUL1 = 4'd7;
    localparam logic [3:0] S_MUL2 = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_SUM  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    localparam logic signed [SUM_W-1:0] VMAX = SUM_W'((64'sd1 <<< (VAL_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] VMIN = -VMAX - SUM_W'(1);

    logic [3:0]              r_state;
    logic [CNT_W-1:0]        r_pc;
    logic [CNT_W-1:0]        r_n;
    logic [CNT_W-1:0]        r_addr;
    logic                    r_pend;
    logic [IDX_W-1:0]        r_pidx;
    logic                    r_found;
    logic signed [DIFF_W-1:0] r_bdist;
    logic [IDX_W-1:0]        r_best;
    logic [IDX_W-1:0]        r_a;
    logic signed [VAL_W-1:0] r_q;
    logic                    r_eob;
    logic                    r_op;
    logic signed [VAL_W-1:0] r_x0, r_y0, r_x1, r_y1;
    logic [DIFF_W-1:0]       r_m1, r_m2, r_m3;
    logic                    r_neg;
    logic [MLO_W+DIFF_W-1:0] r_p0;
    logic [MHI_W+DIFF_W-1:0] r_p1;
    logic                    r_dstart;
    logic [PROD_W-1:0]       r_dvd;
    t_out_item               r_res;
    t_out_item               r_out;
    logic                    r_ovalid;

    logic                    accept;
    logic [IDX_W-1:0]        rd_addr;
    logic signed [VAL_W-1:0] rd_x, rd_y;
    logic signed [DIFF_W-1:0] q_dist;
    logic [CNT_W-1:0]        n_clamp;
    logic signed [DIFF_W-1:0] dx, dy, off;
    logic [PROD_W-1:0]       quo;
    logic                    div_done;
    logic signed [SUM_W-1:0] sum;
    logic                    out_free;
    t_div_req                div_req;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_ovalid || i_out_ready;

    always_comb begin
        if (r_pc < CNT_W'(2)) begin
            n_clamp = CNT_W'(2);
        end else if (r_pc > CNT_W'(DEPTH)) begin
            n_clamp = CNT_W'(DEPTH);
        end else begin
            n_clamp = r_pc;
        end
    end

    always_comb begin
        unique case (r_state)
            S_F0:    rd_addr = r_a;
            S_F1:    rd_addr = r_a + 1'b1;
            default: rd_addr = r_addr[IDX_W-1:0];
        endcase
    end

    pli_table u_table (
        .i_clk   (i_clk),
        .i_we    (accept && i_in_data.operation == OP_LOAD
                  && {1'b0, i_in_data.entry_index} < CNT_W'(DEPTH)),
        .i_waddr (i_in_data.entry_index),
        .i_wx    (i_in_data.x_value),
        .i_wy    (i_in_data.y_value),
        .i_raddr (rd_addr),
        .o_rx    (rd_x),
        .o_ry    (rd_y)
    );

    assign div_req = '{start: r_dstart, dividend: r_dvd, divisor: r_m3};

    pli_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    assign q_dist = DIFF_W'(r_q) - DIFF_W'(rd_x);
    assign dx     = DIFF_W'(r_x1) - DIFF_W'(r_x0);
    assign dy     = DIFF_W'(r_y1) - DIFF_W'(r_y0);
    assign off    = DIFF_W'(r_q) - DIFF_W'(r_x0);
    assign sum  = r_neg ? (SUM_W'(r_y0) - SUM_W'(quo)) : (SUM_W'(r_y0) + SUM_W'(quo));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= CNT_W'(2);
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (i_cfg_we) begin
                r_pc <= i_cfg_data;
            end
            if (r_ovalid && i_out_ready && r_state != S_FIN) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_q     <= i_in_data.x_value;
                        r_eob   <= i_in_data.end_of_batch;
                        r_op    <= i_in_data.operation;
                        r_n     <= n_clamp;
                        r_addr  <= '0;
                        r_pend  <= 1'b0;
                        r_found <= 1'b0;
                        r_best  <= '0;
                        r_res   <= '{result_y: '0, status: ST_OK, segment_index: '0,
                                     batch_end: i_in_data.end_of_batch};
                        r_state <= (i_in_data.operation == OP_LOAD) ? S_FIN : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_pend && q_dist >= 0 && (!r_found || q_dist < r_bdist)) begin
                        r_found <= 1'b1;
                        r_bdist <= q_dist;
                        r_best  <= r_pidx;
                    end
                    if (r_addr < r_n) begin
                        r_pidx <= r_addr[IDX_W-1:0];
                        r_pend <= 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                        if (!r_pend) begin
                            r_a <= ({1'b0, r_best} < r_n - 1'b1) ? r_best : r_best - 1'b1;
                            if (r_found) begin
                                r_state <= S_F0;
                            end else begin
                                r_res.status <= ST_BELOW;
                                r_state      <= S_FIN;
                            end
                        end
                    end
                end
                S_F0: r_state <= S_F1;
                S_F1: begin
                    r_x0    <= rd_x;
                    r_y0    <= rd_y;
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_x1    <= rd_x;
                    r_y1    <= rd_y;
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    r_res.segment_index <= r_best;
                    if (dx == '0) begin
                        r_res.result_y <= (r_best == r_a) ? r_y0 : r_y1;
                        r_res.status   <= ST_ZERO;
                        r_state        <= S_FIN;
                    end else begin
                        r_m1    <= dy[DIFF_W-1] ? -dy : dy;
                        r_m2    <= off[DIFF_W-1] ? -off : off;
                        r_m3    <= dx[DIFF_W-1] ? -dx : dx;
                        r_neg   <= dy[DIFF_W-1] ^ off[DIFF_W-1] ^ dx[DIFF_W-1];
                        r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_p0    <= r_m1 * r_m2[MLO_W-1:0];
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_p1    <= r_m1 * r_m2[DIFF_W-1:MLO_W];
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_dvd    <= PROD_W'(r_p0) + {r_p1, {MLO_W{1'b0}}};
                    r_dstart <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (sum > VMAX) begin
                        r_res.result_y <= VMAX[VAL_W-1:0];
                        r_res.status   <= ST_SAT;
                    end else if (sum < VMIN) begin
                        r_res.result_y <= VMIN[VAL_W-1:0];
                        r_res.status   <= ST_SAT;
                    end else begin
                        r_res.result_y <= sum[VAL_W-1:0];
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out    <= r_res;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // scan address never runs past the clamped count
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_addr <= r_n))
        else $error("scan address beyond point count");

    // divider completes only while a query waits on it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider done outside divide state");

    // load beats answer with zero value and ok status
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_op == OP_LOAD) |->
            (r_res.status == ST_OK && r_res.result_y == '0))
        else $error("load result not zero");

    // input is taken only with the search state cleared for a new beat
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_SCAN || r_state == S_FIN) && !r_pend)
        else $error("bad state after accept");

endmodule

>>> tb/sv/piecewise_linear_interpolator_tb.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_tb
// Loads breakpoint tables, runs directed and random queries over several
// point_count settings and checks every output beat against a predicted
// interpolation, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator_tb;

    import pli_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out_item         o_out_data;
    logic              i_cfg_we;
    logic [CNT_W-1:0]  i_cfg_data;

    piecewise_linear_interpolator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    t_in_item   pending_items[$];
    t_out_item  expected_results[$];
    longint     bp_x[DEPTH];
    longint     bp_y[DEPTH];
    longint     plan_x[DEPTH];
    logic [CNT_W-1:0] point_count;
    int         error_count = 0;
    bit         beat_taken = 0;
    bit         idle_mode = 0;
    bit         stall_req = 0;

    function automatic t_out_item interpolate(t_in_item item);
        t_out_item r;
        int n, best, a;
        bit found;
        longint q_x, dist_q, best_dist, dx, dy, off;
        logic [127:0] mdx, mdy, moff, quot;
        logic signed [127:0] sum, squot;
        bit neg;
        r = '0;
        r.batch_end = item.end_of_batch;
        found = 0;
        best = 0;
        best_dist = 0;
        if (item.operation == OP_LOAD) begin
            bp_x[item.entry_index] = longint'(item.x_value);
            bp_y[item.entry_index] = longint'(item.y_value);
            return r;
        end
        n = point_count;
        if (n < 2) n = 2;
        if (n > DEPTH) n = DEPTH;
        q_x = longint'(item.x_value);
        for (int i = 0; i < n; i++) begin
            dist_q = q_x - bp_x[i];
            if (dist_q >= 0 && (!found || dist_q < best_dist)) begin
                found = 1;
                best_dist = dist_q;
                best = i;
            end
        end
        if (!found) begin
            r.status = ST_BELOW;
            return r;
        end
        r.segment_index = IDX_W'(best);
        a = (best < n - 1) ? best : best - 1;
        dx = bp_x[a+1] - bp_x[a];
        dy = bp_y[a+1] - bp_y[a];
        off = q_x - bp_x[a];
        if (dx == 0) begin
            r.status = ST_ZERO;
            r.result_y = 32'(bp_y[best]);
            return r;
        end
        neg = (dy < 0) ^ (off < 0) ^ (dx < 0);
        mdy = 128'((dy < 0) ? -dy : dy);
        moff = 128'((off < 0) ? -off : off);
        mdx = 128'((dx < 0) ? -dx : dx);
        quot = (mdy * moff) / mdx;
        if (quot > (128'd1 << 62)) quot = 128'd1 << 62;
        squot = quot;
        sum = 128'(bp_y[a]);
        sum = neg ? sum - squot : sum + squot;
        if (sum > 128'sd2147483647) begin
            sum = 128'sd2147483647;
            r.status = ST_SAT;
        end else if (sum < -128'sd2147483648) begin
            sum = -128'sd2147483648;
            r.status = ST_SAT;
        end
        r.result_y = sum[31:0];
        return r;
    endfunction

    // input side: payload changes only at the falling edge
    always @(posedge i_clk) begin
        beat_taken <= i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_results.push_back(interpolate(i_in_data));
    end

    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !beat_taken) begin
            i_in_valid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            i_in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            i_in_valid <= 1'b1;
            i_in_data <= pending_items.pop_front();
            if (idle_mode) begin
                if (burst_left == 0) burst_left = $urandom_range(1, 12);
                burst_left--;
                if (burst_left == 0) gap_left = $urandom_range(1, 15);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    int stall_left = 0;
    bit stall_done = 0;
    int rx_len = 0;
    bit rx_on = 1;

    always @(negedge i_clk) begin
        if (stall_req && !stall_done) begin
            stall_done = 1;
            stall_left = 3000;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (!idle_mode) begin
            i_out_ready <= 1'b1;
        end else begin
            if (rx_len == 0) begin
                rx_len = $urandom_range(1, 20);
                rx_on = ($urandom_range(0, 2) != 0);
            end
            rx_len--;
            i_out_ready <= rx_on;
        end
    end

    always @(posedge i_clk) begin
        t_out_item exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected beat %p", $realtime, o_out_data);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (o_out_data.result_y !== exp_r.result_y) begin
                    $display("%0t: result_y expected %h actual %h", $realtime,
                             exp_r.result_y, o_out_data.result_y);
                    error_count++;
                end
                if (o_out_data.status !== exp_r.status) begin
                    $display("%0t: status expected %0d actual %0d", $realtime,
                             exp_r.status, o_out_data.status);
                    error_count++;
                end
                if (o_out_data.segment_index !== exp_r.segment_index) begin
                    $display("%0t: segment_index expected %0d actual %0d", $realtime,
                             exp_r.segment_index, o_out_data.segment_index);
                    error_count++;
                end
                if (o_out_data.batch_end !== exp_r.batch_end) begin
                    $display("%0t: batch_end expected %0d actual %0d", $realtime,
                             exp_r.batch_end, o_out_data.batch_end);
                    error_count++;
                end
            end
        end
    end

    task automatic push_load(int idx, logic [31:0] x, logic [31:0] y);
        t_in_item it;
        it.operation = OP_LOAD;
        it.entry_index = IDX_W'(idx);
        it.x_value = x;
        it.y_value = y;
        it.end_of_batch = 1'($urandom_range(0, 1));
        plan_x[idx] = longint'($signed(x));
        pending_items.push_back(it);
    endtask

    task automatic push_query(logic [31:0] x, bit eob);
        t_in_item it;
        it.operation = OP_QUERY;
        it.entry_index = IDX_W'($urandom);
        it.x_value = x;
        it.y_value = $urandom;
        it.end_of_batch = eob;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        point_count = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic fill_table(int kind);
        longint x;
        logic [31:0] y;
        x = longint'(-$signed(32'($urandom_range(0, 32'h7fffffff))));
        for (int i = 0; i < DEPTH; i++) begin
            case (kind)
                0: x = x + $urandom_range(1, 32'h03ffffff);
                1: x = longint'($signed(32'($urandom)));
                2: x = x + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 32'h00ffffff));
                default: x = x + $urandom_range(1, 32'h000fffff);
            endcase
            if (x > 64'sd2147483647) x = 64'sd2147483647;
            y = (kind == 3) ? (($urandom_range(0, 1) != 0) ? 32'h7ffff000 + $urandom_range(0, 4095)
                                                          : 32'h80000000 + $urandom_range(0, 4095))
                            : $urandom;
            push_load(i, x[31:0], y);
        end
    endtask

    function automatic logic [31:0] pick_query();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3) return $urandom;
        if (k == 3) return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
        if (k == 4) return 32'(plan_x[$urandom_range(0, DEPTH - 1)]);
        return 32'(plan_x[$urandom_range(0, DEPTH - 1)]
                   + $signed(32'($urandom_range(0, 8191))) - 4096);
    endfunction

    logic [CNT_W-1:0] count_list[12] = '{7'd2, 7'd64, 7'd0, 7'd1, 7'd127, 7'd65,
                                         7'd3, 7'd63, 7'd2, 7'd64, 7'd17, 7'd40};

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        point_count = 2;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: ramp table with a zero-width pair and a steep last segment
        for (int i = 0; i < DEPTH; i++)
            push_load(i, (i - 32) * 262144, i * 65536);
        push_load(5, (4 - 32) * 262144, 32'h00123456);
        push_load(62, (62 - 32) * 262144, 32'h7fff0000);
        push_load(63, (63 - 32) * 262144, 32'h80000000);
        push_query(32'h80000000, 0);
        push_query(-32 * 262144, 1);
        push_query(-32 * 262144 + 131072, 0);
        push_query(32'h7fffffff, 1);
        drain();
        write_count(7'd64);
        push_query((4 - 32) * 262144, 0);
        push_query((4 - 32) * 262144 + 100, 1);
        push_query(32'h7fffffff, 0);
        push_query((62 - 32) * 262144 + 1000, 1);
        push_query(-33 * 262144, 0);
        push_query((63 - 32) * 262144, 1);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            idle_mode = (ph % 4 != 1);
            write_count((ph == 11) ? 7'($urandom_range(0, 127)) : count_list[ph]);
            fill_table(ph % 4);
            for (int j = 0; j < 80; j++) begin
                if ($urandom_range(0, 9) == 0)
                    push_load($urandom_range(0, DEPTH - 1), $urandom, $urandom);
                else
                    push_query(pick_query(), $urandom_range(0, 3) == 0);
            end
            if (ph == 2) stall_req = 1;
            drain();
        end

        repeat (300) @(posedge i_clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
src/pli_pkg.sv
src/pli_table.sv
src/pli_divider.sv
src/piecewise_linear_interpolator.sv
tb/sv/piecewise_linear_interpolator_tb.sv
